### design/cps_pkg.sv
package cps_pkg;

  localparam int unsigned WINDOW_BYTES = 11;
  localparam int unsigned LIT_COUNT    = 7;
  localparam int unsigned LIT_MAX      = 11;
  localparam int unsigned FILL_W       = $clog2(WINDOW_BYTES + 1);
  localparam int unsigned LEN_W        = $clog2(LIT_MAX + 1);
  localparam int unsigned OUT_DATA_W   = 48;
  localparam int unsigned REG_IDX_W    = 1;
  localparam int unsigned REG_DATA_W   = 7;

  typedef enum logic [1:0] {
    FUNC_DATA  = 2'd0,
    FUNC_LAST  = 2'd1,
    FUNC_EMPTY = 2'd2,
    FUNC_NULL  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT     = 2'd0,
    VERDICT_NULL       = 2'd1,
    VERDICT_CREDENTIAL = 2'd2
  } verdict_e;

  localparam logic [REG_IDX_W-1:0] REG_PATTERN_ENABLE = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_NUL_TERMINATES = 1'b1;

  typedef logic [WINDOW_BYTES-1:0][7:0] window_t;

  typedef struct packed {
    logic [LIT_COUNT-1:0] pattern_enable;
    logic                 nul_terminates;
  } cfg_t;

  typedef struct packed {
    func_e      func;
    logic [7:0] data_byte;
  } step_t;

  typedef struct packed {
    logic                 valid;
    verdict_e             verdict;
    logic [LIT_COUNT-1:0] match_mask;
    logic [31:0]          reject_total;
  } result_t;

  // Literals stored newest byte first, so entry j lines up with window byte j.
  localparam logic [7:0] LIT_REV [LIT_COUNT][LIT_MAX] = '{
    '{"_", "t", "a", "p", "_", "b", "u", "h", "t", "i", "g"},
    '{"_", "p", "h", "g", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{" ", "N", "I", "G", "E", "B", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"Y", "E", "K", " ", "E", "T", "A", "V", "I", "R", "P"},
    '{"=", "d", "r", "o", "w", "s", "s", "a", "p", 8'h00, 8'h00},
    '{"=", "n", "e", "k", "o", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"=", "t", "e", "r", "c", "e", "s", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [LEN_W-1:0] LIT_LEN [LIT_COUNT] = '{
    LEN_W'(11), LEN_W'(4), LEN_W'(6), LEN_W'(11), LEN_W'(9), LEN_W'(6), LEN_W'(7)
  };

endpackage

### design/cps_match.sv
module cps_match import cps_pkg::*; (
  input  window_t              window_i,
  input  logic [FILL_W-1:0]    fill_i,
  output logic [LIT_COUNT-1:0] hit_o
);

  always_comb begin
    for (int k = 0; k < LIT_COUNT; k++) begin
      hit_o[k] = (FILL_W'(LIT_LEN[k]) <= fill_i);
      for (int j = 0; j < LIT_MAX; j++) begin
        if ((LEN_W'(j) < LIT_LEN[k]) && (window_i[j] != LIT_REV[k][j])) begin
          hit_o[k] = 1'b0;
        end
      end
    end
  end

endmodule

### design/cps_scan.sv
module cps_scan import cps_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_en_i,
  input  step_t   step_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  window_t              window_q, window_d, window_shift;
  logic [FILL_W-1:0]    fill_q, fill_d, fill_shift;
  logic [LIT_COUNT-1:0] found_q, found_d, hit;
  logic                 stopped_q, stopped_d;
  logic [31:0]          reject_q, reject_d;
  logic                 take, halt, end_buf;
  logic [LIT_COUNT-1:0] mask;

  assign window_shift = {window_q[WINDOW_BYTES-2:0], step_i.data_byte};
  assign fill_shift   = (fill_q == FILL_W'(WINDOW_BYTES)) ? fill_q : fill_q + FILL_W'(1);

  cps_match u_match (
    .window_i (window_shift),
    .fill_i   (fill_shift),
    .hit_o    (hit)
  );

  always_comb begin
    take      = (step_i.func == FUNC_DATA) || (step_i.func == FUNC_LAST);
    halt      = cfg_i.nul_terminates && (step_i.data_byte == 8'h00);
    window_d  = window_q;
    fill_d    = fill_q;
    found_d   = found_q;
    stopped_d = stopped_q;
    reject_d  = reject_q;
    result_o  = '0;

    if (take && !stopped_q) begin
      if (halt) begin
        stopped_d = 1'b1;
      end else begin
        window_d = window_shift;
        fill_d   = fill_shift;
        found_d  = found_q | hit;
      end
    end

    mask    = found_d & cfg_i.pattern_enable;
    end_buf = (step_i.func != FUNC_DATA);

    if (step_i.func == FUNC_NULL) begin
      result_o.verdict = VERDICT_NULL;
      reject_d         = reject_q + 32'd1;
    end else if (end_buf) begin
      result_o.match_mask = mask;
      if (mask != '0) begin
        result_o.verdict = VERDICT_CREDENTIAL;
        reject_d         = reject_q + 32'd1;
      end else begin
        result_o.verdict = VERDICT_ACCEPT;
      end
    end

    result_o.valid        = step_en_i && end_buf;
    result_o.reject_total = reject_d;

    if (end_buf) begin
      window_d  = '0;
      fill_d    = '0;
      found_d   = '0;
      stopped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= '0;
      fill_q    <= '0;
      found_q   <= '0;
      stopped_q <= 1'b0;
      reject_q  <= '0;
    end else if (step_en_i) begin
      window_q  <= window_d;
      fill_q    <= fill_d;
      found_q   <= found_d;
      stopped_q <= stopped_d;
      reject_q  <= reject_d;
    end
  end

endmodule

### design/credential_pattern_scanner_core.sv
// Scans a byte stream for seven credential literals and gives one verdict per buffer. Each
// transaction on the slave side carries one byte and a function code; the block takes one
// transaction per clock cycle, and the transaction that ends a buffer passes through the
// input register and its verdict is then held in the result register for the master side.
// One input register and one result register bound a single stage in which all seven
// literal compares run in parallel on the shift window; new input keeps flowing while a
// verdict waits to be taken, and stalls only when a held verdict is not being taken and
// a second buffer end arrives. The configuration port is always ready and must be written
// only while no transaction is in flight. Reset needs no clearing pass.
module credential_pattern_scanner_core import cps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // data_byte
  input  logic [1:0]            s_axis_tuser,  // func
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // verdict [1:0], match_mask [8:2], reject_total [40:9], zero fill above
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [REG_IDX_W-1:0]  cfg_addr_i,
  input  logic [REG_DATA_W-1:0] cfg_data_i
);

  logic                  in_valid_q, in_valid_d;
  step_t                 in_step_q;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q;
  cfg_t                  cfg_q, cfg_d;
  logic                  out_free, step_en;
  result_t               result;

  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step_en       = in_valid_q && ((in_step_q.func == FUNC_DATA) || out_free);
  assign s_axis_tready = !in_valid_q || step_en;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  cps_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .step_i    (in_step_q),
    .cfg_i     (cfg_q),
    .result_o  (result)
  );

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_PATTERN_ENABLE: cfg_d.pattern_enable = cfg_data_i[LIT_COUNT-1:0];
        REG_NUL_TERMINATES: cfg_d.nul_terminates = cfg_data_i[0];
        default: cfg_d = cfg_q;
      endcase
    end

    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end

    out_valid_d = out_valid_q;
    if (result.valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_q       <= '{pattern_enable: '1, nul_terminates: 1'b0};
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      cfg_q       <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_step_q <= '{func: func_e'(s_axis_tuser), data_byte: s_axis_tdata};
    end
    if (result.valid) begin
      out_data_q <= {(OUT_DATA_W - 41)'(0), result.reject_total, result.match_mask,
                     result.verdict};
    end
  end

endmodule
